// ===== src/rkc_pkg.sv =====
// shared constants and types for the rgb kernel convolution unit
`timescale 1ns / 1ps
package rkc_pkg;

  localparam int KSIZE      = 5;
  localparam int HALF       = KSIZE / 2;
  localparam int MAX_LINE   = 1024;
  localparam int COEF_BITS  = 12;
  localparam int FRAC_BITS  = 8;
  localparam int NCH        = 3;
  localparam int CH_W       = 8;
  localparam int PIX_W      = NCH * CH_W;
  localparam int COL_W      = $clog2(MAX_LINE);
  localparam int LEN_W      = 11;
  localparam int CNT_W      = 16;
  localparam int POS_W      = CNT_W + 1;
  localparam int DLY_W      = LEN_W + 1;
  localparam int REG_W      = 60;
  localparam int LINES      = KSIZE - 1;
  localparam int LBUF_W     = LINES * PIX_W;
  localparam int PROD_W     = COEF_BITS + CH_W + 1;
  localparam int SUM_W      = PROD_W + 7;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  // configuration register indexes
  localparam logic [2:0] REG_LINE_LENGTH = 3'd0;
  localparam logic [2:0] REG_LINE_COUNT  = 3'd1;
  localparam logic [2:0] REG_COEF_ROW0   = 3'd2;
  localparam logic [2:0] REG_COEF_ROW1   = 3'd3;
  localparam logic [2:0] REG_COEF_ROW2   = 3'd4;
  localparam logic [2:0] REG_COEF_ROW3   = 3'd5;
  localparam logic [2:0] REG_COEF_ROW4   = 3'd6;

  // item kinds on in_tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [KSIZE-1:0] row_ok;
    logic [KSIZE-1:0] col_ok;
  } tap_meta_t;

endpackage

// ===== src/rkc_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module rkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rgb_kernel_convolution_unit.sv =====
// streaming 5x5 rgb convolution with a column line buffer and output queue
// throughput: one item per cycle while in_tready is high; a result is queued after the item
// that completes its window, which is the item 2*line_length+2 positions later
// the line buffer ram read, the window register and the 3-stage multiply-add tree set the latency
// reset (rst_n low, synchronous): geometry 640x480, identity kernel, positions and
// queue cleared; line buffer contents stay undefined and are masked at the image edge
`timescale 1ns / 1ps
module rgb_kernel_convolution_unit
  import rkc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic             in_tuser,   // op [0]
  // result channel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PIX_W-1:0] out_tdata,  // out_red [7:0], out_green [15:8], out_blue [23:16]
  output logic             out_tlast,
  // configuration
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [REG_W-1:0] cfg_wdata
);

  // configuration registers
  logic [LEN_W-1:0] line_length_r;
  logic [CNT_W-1:0] line_count_r;
  logic [REG_W-1:0] coef_r [KSIZE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= LEN_W'(640);
      line_count_r  <= CNT_W'(480);
      for (int i = 0; i < KSIZE; i++) begin
        coef_r[i] <= (i == HALF) ? (REG_W'(1) << (HALF * COEF_BITS + FRAC_BITS)) : '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LINE_LENGTH: line_length_r <= cfg_wdata[LEN_W-1:0];
        REG_LINE_COUNT:  line_count_r  <= cfg_wdata[CNT_W-1:0];
        REG_COEF_ROW0:   coef_r[0]     <= cfg_wdata;
        REG_COEF_ROW1:   coef_r[1]     <= cfg_wdata;
        REG_COEF_ROW2:   coef_r[2]     <= cfg_wdata;
        REG_COEF_ROW3:   coef_r[3]     <= cfg_wdata;
        REG_COEF_ROW4:   coef_r[4]     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [LEN_W-1:0] len_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic [DLY_W-1:0] delay;
  logic [POS_W-1:0] cnt_pos;

  always_comb begin
    if (line_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (line_length_r > LEN_W'(MAX_LINE)) begin
      len_eff = LEN_W'(MAX_LINE);
    end else begin
      len_eff = line_length_r;
    end
    cnt_eff = (line_count_r == '0) ? CNT_W'(1) : line_count_r;
    delay   = DLY_W'(HALF) * {1'b0, len_eff} + DLY_W'(HALF);
    cnt_pos = {1'b0, cnt_eff};
  end

  // position state
  logic [COL_W-1:0] in_fast_r, in_fast_nxt, out_fast_r, out_fast_nxt;
  logic [POS_W-1:0] in_slow_r, in_slow_nxt, out_slow_r, out_slow_nxt;
  logic [DLY_W-1:0] ahead_r, ahead_nxt;
  logic             accept;
  logic             acc_emit, acc_last;
  logic [KSIZE-1:0] acc_row_ok, acc_col_ok;

  assign accept = in_tvalid && in_tready;

  // position bookkeeping for one accepted item
  always_comb begin
    logic [LEN_W-1:0] fi, fo;
    logic [POS_W-1:0] so;
    logic [POS_W:0]   rt;
    logic [LEN_W:0]   ct;
    in_fast_nxt  = in_fast_r;
    in_slow_nxt  = in_slow_r;
    out_fast_nxt = out_fast_r;
    out_slow_nxt = out_slow_r;
    ahead_nxt    = ahead_r;
    acc_emit     = 1'b0;
    acc_last     = 1'b0;
    fi = {1'b0, in_fast_r} + LEN_W'(1);
    fo = {1'b0, out_fast_r} + LEN_W'(1);
    so = out_slow_r;
    // tap masks for the output position
    for (int i = 0; i < KSIZE; i++) begin
      rt = {1'b0, out_slow_r} + (POS_W+1)'(i);
      acc_row_ok[i] = (rt >= (POS_W+1)'(HALF)) &&
                      ((rt - (POS_W+1)'(HALF)) < {1'b0, cnt_pos});
      ct = {2'b0, out_fast_r} + (LEN_W+1)'(i);
      acc_col_ok[i] = (ct >= (LEN_W+1)'(HALF)) &&
                      ((ct - (LEN_W+1)'(HALF)) < {1'b0, len_eff});
    end
    if (accept) begin
      // input position advance
      if (fi >= len_eff) begin
        in_fast_nxt = '0;
        if (in_slow_r != '1) begin
          in_slow_nxt = in_slow_r + POS_W'(1);
        end
      end else begin
        in_fast_nxt = fi[COL_W-1:0];
      end
      if (out_slow_r >= cnt_pos) begin
        in_fast_nxt  = '0;
        in_slow_nxt  = '0;
        out_fast_nxt = '0;
        out_slow_nxt = '0;
        ahead_nxt    = '0;
      end else if (ahead_r >= delay) begin
        acc_emit = 1'b1;
        acc_last = (out_slow_r == cnt_pos - POS_W'(1)) &&
                   ({1'b0, out_fast_r} >= len_eff - LEN_W'(1));
        if (fo >= len_eff) begin
          out_fast_nxt = '0;
          so = (out_slow_r != '1) ? out_slow_r + POS_W'(1) : out_slow_r;
        end else begin
          out_fast_nxt = fo[COL_W-1:0];
        end
        out_slow_nxt = so;
        if (acc_last || so >= cnt_pos) begin
          in_fast_nxt  = '0;
          in_slow_nxt  = '0;
          out_fast_nxt = '0;
          out_slow_nxt = '0;
          ahead_nxt    = '0;
        end
      end else begin
        ahead_nxt = ahead_r + DLY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_fast_r  <= '0;
      in_slow_r  <= '0;
      out_fast_r <= '0;
      out_slow_r <= '0;
      ahead_r    <= '0;
    end else begin
      in_fast_r  <= in_fast_nxt;
      in_slow_r  <= in_slow_nxt;
      out_fast_r <= out_fast_nxt;
      out_slow_r <= out_slow_nxt;
      ahead_r    <= ahead_nxt;
    end
  end

  // stage 1: line buffer read in flight
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_addr_r;
  pixel_t           s1_px_r;
  tap_meta_t        s1_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r <= in_fast_r;
      s1_px_r   <= (in_tuser == OP_PIXEL) ? in_tdata : '0;
      s1_meta_r <= '{emit: acc_emit, last: acc_last, row_ok: acc_row_ok,
                     col_ok: acc_col_ok};
    end
  end

  // line buffer: one word per column holds the four previous lines
  // every item shifts its column, past the frame end too, so rows stay one line apart
  logic [LBUF_W-1:0] lb_rdata, lb_old, lb_wdata;
  logic              lb_we;
  logic              fw_valid_r;
  logic [COL_W-1:0]  fw_addr_r;
  logic [LBUF_W-1:0] fw_word_r;

  rkc_ram #(
    .WIDTH(LBUF_W),
    .DEPTH(MAX_LINE)
  ) u_line_buf (
    .clk  (clk),
    .we   (lb_we),
    .waddr(s1_addr_r),
    .wdata(lb_wdata),
    .raddr(in_fast_r),
    .rdata(lb_rdata)
  );

  // forward the previous write when the read raced it on the same column
  assign lb_old   = (fw_valid_r && fw_addr_r == s1_addr_r) ? fw_word_r : lb_rdata;
  assign lb_wdata = {lb_old[LBUF_W-PIX_W-1:0], s1_px_r};
  assign lb_we    = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_valid_r <= 1'b0;
    end else begin
      fw_valid_r <= lb_we;
    end
  end

  always_ff @(posedge clk) begin
    if (lb_we) begin
      fw_addr_r <= s1_addr_r;
      fw_word_r <= lb_wdata;
    end
  end

  // window shift: row KSIZE-1 is the newest line
  pixel_t    win_r [KSIZE][KSIZE];
  logic      s2_valid_r;
  tap_meta_t s2_meta_r;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int i = 0; i < KSIZE; i++) begin
        for (int j = 0; j < KSIZE - 1; j++) begin
          win_r[i][j] <= win_r[i][j+1];
        end
      end
      win_r[KSIZE-1][KSIZE-1] <= s1_px_r;
      for (int i = 0; i < KSIZE - 1; i++) begin
        win_r[i][KSIZE-1] <= lb_old[(KSIZE-2-i)*PIX_W +: PIX_W];
      end
      s2_meta_r <= s1_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r && s1_meta_r.emit;
    end
  end

  // stage 2: masked tap products
  logic signed [PROD_W-1:0] prod_r [NCH][KSIZE][KSIZE];
  logic                     s3_valid_r, s3_last_r;

  always_ff @(posedge clk) begin
    logic signed [COEF_BITS-1:0] cf;
    logic signed [CH_W:0]        ch;
    for (int k = 0; k < NCH; k++) begin
      for (int i = 0; i < KSIZE; i++) begin
        for (int j = 0; j < KSIZE; j++) begin
          cf = coef_r[i][j*COEF_BITS +: COEF_BITS];
          ch = {1'b0, win_r[i][j][k*CH_W +: CH_W]};
          if (s2_meta_r.row_ok[i] && s2_meta_r.col_ok[j]) begin
            prod_r[k][i][j] <= PROD_W'(cf * ch);
          end else begin
            prod_r[k][i][j] <= '0;
          end
        end
      end
    end
    s3_last_r <= s2_meta_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  // stage 3: row sums
  logic signed [SUM_W-1:0] row_sum_r [NCH][KSIZE];
  logic                    s4_valid_r, s4_last_r;

  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] acc;
    for (int k = 0; k < NCH; k++) begin
      for (int i = 0; i < KSIZE; i++) begin
        acc = '0;
        for (int j = 0; j < KSIZE; j++) begin
          acc = acc + SUM_W'(prod_r[k][i][j]);
        end
        row_sum_r[k][i] <= acc;
      end
    end
    s4_last_r <= s3_last_r;
  end

  // stage 4: channel totals
  logic signed [SUM_W-1:0] total_r [NCH];
  logic                    s5_valid_r, s5_last_r;

  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] acc;
    for (int k = 0; k < NCH; k++) begin
      acc = '0;
      for (int i = 0; i < KSIZE; i++) begin
        acc = acc + row_sum_r[k][i];
      end
      total_r[k] <= acc;
    end
    s5_last_r <= s4_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  // stage 5: truncate and clamp
  pixel_t res_px;

  always_comb begin
    logic [SUM_W-FRAC_BITS-1:0] sh;
    for (int k = 0; k < NCH; k++) begin
      sh = total_r[k][SUM_W-1:FRAC_BITS];
      if (total_r[k] <= 0) begin
        res_px[k*CH_W +: CH_W] = '0;
      end else if (sh > (SUM_W-FRAC_BITS)'(255)) begin
        res_px[k*CH_W +: CH_W] = '1;
      end else begin
        res_px[k*CH_W +: CH_W] = sh[CH_W-1:0];
      end
    end
  end

  // output queue, credit checked against items in flight
  logic [PIX_W:0]     fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   fifo_cnt_r;
  logic [FIFO_AW:0]   inflight;
  logic               push, pop;

  assign inflight = (FIFO_AW+1)'(s1_valid_r) + (FIFO_AW+1)'(s2_valid_r) +
                    (FIFO_AW+1)'(s3_valid_r) + (FIFO_AW+1)'(s4_valid_r) +
                    (FIFO_AW+1)'(s5_valid_r);
  assign in_tready  = (fifo_cnt_r + inflight) < (FIFO_AW+1)'(FIFO_DEPTH);
  assign push       = s5_valid_r;
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = fifo_cnt_r != '0;
  assign out_tdata  = fifo_r[rd_ptr_r][PIX_W-1:0];
  assign out_tlast  = fifo_r[rd_ptr_r][PIX_W];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= {s5_last_r, res_px};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  // queue credit covers every item still in the pipeline
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_cnt_r + inflight) <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("output queue credit exceeded");

  // a result never lands in a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_cnt_r < (FIFO_AW+1)'(FIFO_DEPTH)) || pop)
    else $error("output queue overflow");

  // a forwarded word always comes from the write in the previous cycle
  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    fw_valid_r |-> $past(lb_we))
    else $error("line buffer forward without a write");

endmodule
